@@ rtl/vrp_pkg.sv @@
// Package: sizes, register numbers, command codes and power-on table of the video RAM port.
`timescale 1ns / 1ps
package vrp_pkg;

  localparam int VRAM_ADDR_BITS = 16;
  localparam int VRAM_DEPTH     = 1 << VRAM_ADDR_BITS;
  localparam int REG_COUNT      = 38;
  localparam int REG_IDX_BITS   = $clog2(REG_COUNT);
  localparam int REG_SEL_BITS   = 6;
  localparam int PAIR_BITS      = 16;
  localparam int CNT_BITS       = 9;
  localparam int INIT_COUNT     = 38;

  localparam logic [1:0] CMD_RD_STATUS = 2'd0;
  localparam logic [1:0] CMD_RD_DATA   = 2'd1;
  localparam logic [1:0] CMD_WR_SELECT = 2'd2;
  localparam logic [1:0] CMD_WR_DATA   = 2'd3;

  localparam logic [REG_SEL_BITS-1:0] REG_UPD_HI  = 6'd18;
  localparam logic [REG_SEL_BITS-1:0] REG_UPD_LO  = 6'd19;
  localparam logic [REG_SEL_BITS-1:0] REG_MODE    = 6'd24;
  localparam logic [REG_SEL_BITS-1:0] REG_BLOCK   = 6'd30;
  localparam logic [REG_SEL_BITS-1:0] REG_DATA    = 6'd31;
  localparam logic [REG_SEL_BITS-1:0] REG_SRC_HI  = 6'd32;
  localparam logic [REG_SEL_BITS-1:0] REG_SRC_LO  = 6'd33;

  localparam int MODE_COPY_BIT = 7;

  localparam logic [7:0] STATUS_READY = 8'h80;
  localparam logic [7:0] STATUS_BUSY  = 8'h36;
  localparam logic [7:0] BYTE_NONE    = 8'hFF;

  localparam logic [7:0] REG_INIT_TABLE [0:INIT_COUNT-1] = '{
    8'd126, 8'd80,  8'd102, 8'd73,  8'd32,  8'd224, 8'd25,  8'd29,
    8'd252, 8'd231, 8'd160, 8'd231, 8'd0,   8'd0,   8'd0,   8'd0,
    8'd0,   8'd0,   8'd15,  8'd228, 8'd8,   8'd0,   8'd120, 8'd232,
    8'd32,  8'd71,  8'd240, 8'd0,   8'd63,  8'd21,  8'd79,  8'd0,
    8'd0,   8'd0,   8'd125, 8'd100, 8'd245, 8'd63
  };

  function automatic logic [7:0] reg_init(input logic [REG_SEL_BITS-1:0] idx);
    logic [7:0] v;
    v = 8'd0;
    if ({1'b0, idx} < (REG_SEL_BITS+1)'(INIT_COUNT)) v = REG_INIT_TABLE[idx];
    return v;
  endfunction

endpackage

@@ rtl/vrp_if.sv @@
// Interfaces: command word channel and response word channel.
`timescale 1ns / 1ps
interface vrp_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] wdata;
  modport source (output valid, output cmd, output wdata, input ready);
  modport sink   (input valid, input cmd, input wdata, output ready);
endinterface

interface vrp_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] rdata;
  modport source (output valid, output rdata, input ready);
  modport sink   (input valid, input rdata, output ready);
endinterface

@@ rtl/video_ram_port_block_fill_copy.sv @@
// Top level: indirect register port with video RAM access, block fill and block copy.
`timescale 1ns / 1ps
// Each command word yields one response word. After reset the block clears
// the video RAM and loads the register file from its power-on table; no
// command word is taken then. After that a status read, a plain data read,
// or a write to an ordinary register is answered straight away; a register
// select first reads the register RAM; a write to register 31 writes the
// video RAM; a data read of register 31 waits for a registered video RAM
// read. A write to register 30 runs a block of N bytes: a fill writes each
// byte in turn, while a copy needs a video RAM read followed by its write for
// each copied byte. One shared address incrementer steps both the update
// and the source address. The response register lets the next command be
// taken while a response still waits.
module video_ram_port_block_fill_copy (
  input  logic           clk,
  input  logic           rst,
  vrp_req_if.sink        req,
  vrp_rsp_if.source      rsp
);

  localparam int AB = vrp_pkg::VRAM_ADDR_BITS;
  localparam int SB = vrp_pkg::REG_SEL_BITS;
  localparam int IB = vrp_pkg::REG_IDX_BITS;

  localparam logic [3:0] ST_CLEAR   = 4'd0;
  localparam logic [3:0] ST_IDLE    = 4'd1;
  localparam logic [3:0] ST_DONE    = 4'd2;
  localparam logic [3:0] ST_SEL     = 4'd3;
  localparam logic [3:0] ST_RD31    = 4'd4;
  localparam logic [3:0] ST_RD31W   = 4'd5;
  localparam logic [3:0] ST_WR31    = 4'd6;
  localparam logic [3:0] ST_FILL    = 4'd7;
  localparam logic [3:0] ST_COPY_RD = 4'd8;
  localparam logic [3:0] ST_COPY_WR = 4'd9;

  logic [3:0]                     state;
  logic [AB-1:0]                  clr;
  logic [SB-1:0]                  sel;
  logic [7:0]                     latched;
  logic                           ready_flag;
  logic [vrp_pkg::PAIR_BITS-1:0]  upd_addr;
  logic [vrp_pkg::PAIR_BITS-1:0]  src_addr;
  logic [7:0]                     mode_reg;
  logic [7:0]                     data_reg;
  logic [vrp_pkg::CNT_BITS-1:0]   cnt;
  logic [7:0]                     res;
  logic                           out_valid;
  logic [7:0]                     out_rdata;

  logic          accept;
  logic          sel_ok;
  logic [AB-1:0] inc_in;
  logic [AB-1:0] inc_out;
  logic          vram_we;
  logic [AB-1:0] vram_waddr;
  logic [7:0]    vram_wdata;
  logic [AB-1:0] vram_raddr;
  logic [7:0]    vram_rdata;
  logic          regs_we;
  logic [IB-1:0] regs_waddr;
  logic [7:0]    regs_wdata;
  logic [7:0]    regs_rdata;
  logic [7:0]    sel_byte;
  logic          out_load;

  assign req.ready = (state == ST_IDLE);
  assign accept    = req.valid && req.ready;
  assign sel_ok    = ({1'b0, sel} < (SB+1)'(vrp_pkg::REG_COUNT));

  // shared address incrementer: source during copy reads, update address otherwise
  assign inc_in  = (state == ST_COPY_RD) ? src_addr[AB-1:0] : upd_addr[AB-1:0];
  assign inc_out = inc_in + 1'b1;

  always_comb begin
    vram_we    = 1'b0;
    vram_waddr = upd_addr[AB-1:0];
    vram_wdata = data_reg;
    case (state)
      ST_CLEAR: begin
        vram_we    = 1'b1;
        vram_waddr = clr;
        vram_wdata = 8'd0;
      end
      ST_WR31, ST_FILL: vram_we = 1'b1;
      ST_COPY_WR: begin
        vram_we    = 1'b1;
        vram_wdata = vram_rdata;
      end
      default: vram_we = 1'b0;
    endcase
  end

  assign vram_raddr = (state == ST_COPY_RD) ? src_addr[AB-1:0] : upd_addr[AB-1:0];

  always_comb begin
    regs_we    = 1'b0;
    regs_waddr = sel[IB-1:0];
    regs_wdata = req.wdata;
    if (state == ST_CLEAR) begin
      regs_we    = (clr < AB'(vrp_pkg::REG_COUNT));
      regs_waddr = clr[IB-1:0];
      regs_wdata = vrp_pkg::reg_init(clr[SB-1:0]);
    end else if (accept && req.cmd == vrp_pkg::CMD_WR_DATA && sel_ok) begin
      regs_we = 1'b1;
    end
  end

  // registers kept in flip-flops shadow their RAM copies on a select read
  always_comb begin
    case (sel)
      vrp_pkg::REG_UPD_HI: sel_byte = upd_addr[15:8];
      vrp_pkg::REG_UPD_LO: sel_byte = upd_addr[7:0];
      vrp_pkg::REG_MODE:   sel_byte = mode_reg;
      vrp_pkg::REG_DATA:   sel_byte = data_reg;
      vrp_pkg::REG_SRC_HI: sel_byte = src_addr[15:8];
      vrp_pkg::REG_SRC_LO: sel_byte = src_addr[7:0];
      default:             sel_byte = regs_rdata;
    endcase
    if (!sel_ok) sel_byte = vrp_pkg::BYTE_NONE;
  end

  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::VRAM_DEPTH)) u_vram (
    .clk   (clk),
    .we    (vram_we),
    .waddr (vram_waddr),
    .wdata (vram_wdata),
    .raddr (vram_raddr),
    .rdata (vram_rdata)
  );

  vrp_ram #(.WIDTH(8), .DEPTH(vrp_pkg::REG_COUNT)) u_regs (
    .clk   (clk),
    .we    (regs_we),
    .waddr (regs_waddr),
    .wdata (regs_wdata),
    .raddr (req.wdata[IB-1:0]),
    .rdata (regs_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr        <= '0;
      sel        <= '0;
      latched    <= 8'd0;
      ready_flag <= 1'b0;
      upd_addr   <= {vrp_pkg::reg_init(vrp_pkg::REG_UPD_HI),
                     vrp_pkg::reg_init(vrp_pkg::REG_UPD_LO)};
      src_addr   <= {vrp_pkg::reg_init(vrp_pkg::REG_SRC_HI),
                     vrp_pkg::reg_init(vrp_pkg::REG_SRC_LO)};
      mode_reg   <= vrp_pkg::reg_init(vrp_pkg::REG_MODE);
      data_reg   <= vrp_pkg::reg_init(vrp_pkg::REG_DATA);
      cnt        <= '0;
      res        <= 8'd0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
        out_rdata <= res;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_CLEAR: begin
          clr <= clr + 1'b1;
          if (&clr) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            case (req.cmd)
              vrp_pkg::CMD_RD_STATUS: begin
                res        <= ready_flag ? vrp_pkg::STATUS_READY : vrp_pkg::STATUS_BUSY;
                ready_flag <= 1'b1;
                state      <= ST_DONE;
              end
              vrp_pkg::CMD_RD_DATA: begin
                if (!ready_flag) begin
                  res        <= vrp_pkg::BYTE_NONE;
                  ready_flag <= 1'b1;
                  state      <= ST_DONE;
                end else if (sel == vrp_pkg::REG_DATA) begin
                  state <= ST_RD31;
                end else begin
                  res   <= latched;
                  state <= ST_DONE;
                end
              end
              vrp_pkg::CMD_WR_SELECT: begin
                sel        <= req.wdata[SB-1:0];
                ready_flag <= 1'b0;
                res        <= 8'd0;
                state      <= ST_SEL;
              end
              default: begin
                ready_flag <= 1'b0;
                res        <= 8'd0;
                if (sel == vrp_pkg::REG_DATA) begin
                  data_reg <= req.wdata;
                  state    <= ST_WR31;
                end else if (sel == vrp_pkg::REG_BLOCK) begin
                  // zero length means 256
                  cnt   <= {req.wdata == 8'd0, req.wdata};
                  state <= mode_reg[vrp_pkg::MODE_COPY_BIT] ? ST_COPY_RD : ST_FILL;
                end else begin
                  state <= ST_DONE;
                  if (sel_ok) begin
                    case (sel)
                      vrp_pkg::REG_UPD_HI: upd_addr[15:8] <= req.wdata;
                      vrp_pkg::REG_UPD_LO: upd_addr[7:0]  <= req.wdata;
                      vrp_pkg::REG_MODE:   mode_reg       <= req.wdata;
                      vrp_pkg::REG_SRC_HI: src_addr[15:8] <= req.wdata;
                      vrp_pkg::REG_SRC_LO: src_addr[7:0]  <= req.wdata;
                      default: ;
                    endcase
                  end
                end
              end
            endcase
          end
        end
        ST_SEL: begin
          latched <= sel_byte;
          state   <= ST_DONE;
        end
        ST_RD31: begin
          upd_addr <= vrp_pkg::PAIR_BITS'(inc_out);
          state    <= ST_RD31W;
        end
        ST_RD31W: begin
          latched <= vram_rdata;
          res     <= vram_rdata;
          state   <= ST_DONE;
        end
        ST_WR31: begin
          upd_addr <= vrp_pkg::PAIR_BITS'(inc_out);
          state    <= ST_DONE;
        end
        ST_FILL: begin
          upd_addr <= vrp_pkg::PAIR_BITS'(inc_out);
          cnt      <= cnt - 1'b1;
          if (cnt == vrp_pkg::CNT_BITS'(1)) state <= ST_DONE;
        end
        ST_COPY_RD: begin
          src_addr <= vrp_pkg::PAIR_BITS'(inc_out);
          state    <= ST_COPY_WR;
        end
        ST_COPY_WR: begin
          upd_addr <= vrp_pkg::PAIR_BITS'(inc_out);
          cnt      <= cnt - 1'b1;
          state    <= (cnt == vrp_pkg::CNT_BITS'(1)) ? ST_DONE : ST_COPY_RD;
        end
        ST_DONE: begin
          if (out_load) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.rdata = out_rdata;

  a_one_word_at_a_time: assert property (@(posedge clk) disable iff (rst)
    accept |=> !req.ready)
    else $error("command word taken while previous one still in work");

  a_block_count_live: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL || state == ST_COPY_RD || state == ST_COPY_WR) |-> cnt != '0)
    else $error("block running with zero byte count");

  a_fill_steps_addr: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL) |=> (upd_addr[AB-1:0] == AB'($past(upd_addr[AB-1:0]) + 1'b1)))
    else $error("fill did not step the update address");

  a_no_response_in_clear: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CLEAR) |-> !rsp.valid)
    else $error("response word during clearing pass");

endmodule

@@ rtl/vrp_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
`timescale 1ns / 1ps
module vrp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule
